// ===== rtl/psf_pkg.sv =====
// ----------------------------------------------------------------------------
// psf_pkg - shared types and constants of the pulse shaping FIR
// Field widths, fixed-point format, item action codes and the beat that
// travels along the chain of tap cells.
// ----------------------------------------------------------------------------
package psf_pkg;

  localparam int unsigned MAX_TAPS_DEF   = 128;
  localparam int unsigned COEF_FRAC_BITS = 15;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned HIST_W   = 15;
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned TAP_W    = 8;
  // signed coefficient times zero-extended history value
  localparam int unsigned PROD_W   = COEF_W + HIST_W + 1;

  localparam logic [TAP_W-1:0] TAP_COUNT_RST = 8'd128;

  localparam int SHAPED_MAX = 32767;
  localparam int SHAPED_MIN = -32768;

  typedef enum logic [0:0] {
    ACT_PROCESS = 1'b0,
    ACT_LOAD    = 1'b1
  } psf_action_e;

  // One beat in flight along the cell chain
  typedef struct packed {
    logic                       valid;
    psf_action_e                action;
    logic                       first;
    logic [IDX_W-1:0]           idx;
    logic signed [COEF_W-1:0]   coef;
    logic [HIST_W-1:0]          hist;   // history value shifted into the next cell
  } psf_token_t;

endpackage

// ===== rtl/psf_cell.sv =====
// ----------------------------------------------------------------------------
// psf_cell - one tap of the systolic shaping chain
// Holds one kernel coefficient and one history sample, adds its product to
// the passing partial sum and hands the beat to the next cell.
// ----------------------------------------------------------------------------
module psf_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned ACC_W    = 40
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [psf_pkg::TAP_W-1:0]           tap_count_i,
  input  psf_pkg::psf_token_t                 tok_i,
  input  logic signed [ACC_W-1:0]             acc_i,
  output psf_pkg::psf_token_t                 tok_o,
  output logic signed [ACC_W-1:0]             acc_o
);

  logic signed [psf_pkg::COEF_W-1:0] kern_q, kern_d;
  logic [psf_pkg::HIST_W-1:0]        hist_q, hist_d;
  logic                              valid_q;
  psf_pkg::psf_token_t               tok_q, tok_d;
  logic signed [ACC_W-1:0]           acc_q, acc_d;
  logic signed [psf_pkg::PROD_W-1:0] prod;
  logic                              is_proc, is_load, active;

  assign is_proc = tok_i.valid && (tok_i.action == psf_pkg::ACT_PROCESS);
  assign is_load = tok_i.valid && (tok_i.action == psf_pkg::ACT_LOAD) &&
                   (32'(tok_i.idx) == CELL_IDX);
  assign active  = (CELL_IDX < 32'(tap_count_i));

  assign prod = $signed(kern_q) * $signed({1'b0, tok_i.hist});

  always_comb begin
    kern_d   = is_load ? tok_i.coef : kern_q;
    hist_d   = is_proc ? tok_i.hist : hist_q;
    tok_d    = tok_i;
    // pass the old sample on; a new signal starts with empty history
    tok_d.hist = tok_i.first ? '0 : hist_q;
    acc_d    = active ? (acc_i + ACC_W'(prod)) : acc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q  <= '0;
      hist_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      kern_q  <= kern_d;
      hist_q  <= hist_d;
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    acc_q <= acc_d;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/psf_fifo.sv =====
// ----------------------------------------------------------------------------
// psf_fifo - result buffer
// Memory-backed queue with a registered output stage; absorbs every result
// in flight while the consumer stalls.
// ----------------------------------------------------------------------------
module psf_fifo #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned W     = 17
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic [W-1:0]  data_q;
  logic          rd_en;

  // refill the output stage whenever it is empty or being taken
  assign rd_en = (cnt_q != '0) && (!out_valid_q || out_ready_i);

  always_comb begin
    wr_ptr_d    = push_i ? wr_ptr_q + AW'(1) : wr_ptr_q;
    rd_ptr_d    = rd_en ? rd_ptr_q + AW'(1) : rd_ptr_q;
    cnt_d       = cnt_q + CW'(push_i) - CW'(rd_en);
    out_valid_d = rd_en ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= data_i;
    end
    if (rd_en) begin
      data_q <= mem[rd_ptr_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = data_q;

endmodule

// ===== rtl/pulse_shaping_fir.sv =====
// ----------------------------------------------------------------------------
// pulse_shaping_fir - detector pulse shaping FIR
// Convolves clamped detector samples with a loadable Q1.15 kernel on a
// systolic chain of tap cells; rounds and saturates each shaped sample.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------
//   in      | input     | in_valid_i / in_ready_o | action, sample, first_of_signal,
//           |           |                         | coef_index, coef_value
//   out     | output    | out_valid_o/out_ready_i | shaped, saturated
//   cfg     | input     | cfg_we_i (no wait)      | cfg_wdata_i -> tap_count
//
// One beat is taken per cycle while in_ready_o is high. A beat walks the
// MAX_TAPS cells one per cycle; its result then passes the rounding stage,
// the buffer write and the buffer output stage, in that order. The chain
// length sets the bulk of the latency.
// Reset clears kernel, history and tap count (to 128) at once; the block takes
// beats in the first cycle after reset. When the output stalls, in_ready_o
// drops only once every buffer slot is promised to a sample in flight.
//
module pulse_shaping_fir #(
  parameter int unsigned MAX_TAPS = psf_pkg::MAX_TAPS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [psf_pkg::TAP_W-1:0]            cfg_wdata_i,
  // input beats
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 action_i,
  input  logic signed [psf_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                 first_of_signal_i,
  input  logic [psf_pkg::IDX_W-1:0]            coef_index_i,
  input  logic signed [psf_pkg::COEF_W-1:0]    coef_value_i,
  // result beats
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [psf_pkg::SAMPLE_W-1:0]  shaped_o,
  output logic                                 saturated_o
);

  // accumulator: full product plus growth over all taps
  localparam int unsigned ACC_W      = psf_pkg::PROD_W + $clog2(MAX_TAPS);
  localparam int unsigned FIFO_DEPTH = 2 ** $clog2(MAX_TAPS + 4);
  localparam int unsigned CAP        = FIFO_DEPTH + 1;   // memory plus output stage
  localparam int unsigned PW         = $clog2(CAP + 1);
  localparam int unsigned RES_W      = psf_pkg::SAMPLE_W + 1;

  logic                          in_accept, out_accept, proc_accept;
  logic [psf_pkg::TAP_W-1:0]     tap_count_q;
  logic [PW-1:0]                 pending_q, pending_d;

  psf_pkg::psf_token_t           tok [MAX_TAPS+1];
  logic signed [ACC_W-1:0]       acc [MAX_TAPS+1];

  logic signed [ACC_W-1:0]       rnd_sum, rnd_q;
  logic                          rnd_hi, rnd_lo;
  logic                          res_valid_q;
  logic signed [psf_pkg::SAMPLE_W-1:0] res_shaped_q, res_shaped_d;
  logic                          res_sat_q;
  logic [RES_W-1:0]              fifo_data;

  assign in_accept   = in_valid_i && in_ready_o;
  assign out_accept  = out_valid_o && out_ready_i;
  assign proc_accept = in_accept && (action_i == psf_pkg::ACT_PROCESS);

  // Credit count: samples taken whose results are not yet delivered. Hold
  // ready low once all buffer slots are spoken for.
  assign in_ready_o = (pending_q < PW'(CAP));
  assign pending_d  = pending_q + PW'(proc_accept) - PW'(out_accept);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= psf_pkg::TAP_COUNT_RST;
      pending_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        tap_count_q <= cfg_wdata_i;
      end
      pending_q <= pending_d;
    end
  end

  // Feed the chain head; non-positive samples enter as zero
  always_comb begin
    tok[0].valid  = in_accept;
    tok[0].action = psf_pkg::psf_action_e'(action_i);
    tok[0].first  = first_of_signal_i;
    tok[0].idx    = coef_index_i;
    tok[0].coef   = coef_value_i;
    tok[0].hist   = (!sample_i[psf_pkg::SAMPLE_W-1] && (sample_i != '0)) ?
                    sample_i[psf_pkg::HIST_W-1:0] : '0;
    acc[0]        = '0;
  end

  // Chain of tap cells: each advances every beat by one cell per cycle, so
  // kernel loads and history shifts meet the partial sums in item order.
  for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
    psf_cell #(
      .CELL_IDX (g),
      .ACC_W    (ACC_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tap_count_i (tap_count_q),
      .tok_i       (tok[g]),
      .acc_i       (acc[g]),
      .tok_o       (tok[g+1]),
      .acc_o       (acc[g+1])
    );
  end

  // Round half up, floor shift, saturate to 16-bit signed
  always_comb begin
    rnd_sum = acc[MAX_TAPS] + ACC_W'(1 << (psf_pkg::COEF_FRAC_BITS - 1));
    rnd_q   = rnd_sum >>> psf_pkg::COEF_FRAC_BITS;
    rnd_hi  = (rnd_q > ACC_W'(psf_pkg::SHAPED_MAX));
    rnd_lo  = (rnd_q < ACC_W'(psf_pkg::SHAPED_MIN));
    if (rnd_hi) begin
      res_shaped_d = psf_pkg::SAMPLE_W'(psf_pkg::SHAPED_MAX);
    end else if (rnd_lo) begin
      res_shaped_d = psf_pkg::SAMPLE_W'(psf_pkg::SHAPED_MIN);
    end else begin
      res_shaped_d = rnd_q[psf_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= tok[MAX_TAPS].valid &&
                     (tok[MAX_TAPS].action == psf_pkg::ACT_PROCESS);
    end
  end

  always_ff @(posedge clk_i) begin
    res_shaped_q <= res_shaped_d;
    res_sat_q    <= rnd_hi || rnd_lo;
  end

  // Result buffer: every credited result has a slot, so a push never drops
  psf_fifo #(
    .DEPTH (FIFO_DEPTH),
    .W     (RES_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid_q),
    .data_i      ({res_sat_q, res_shaped_q}),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (fifo_data)
  );

  assign shaped_o    = fifo_data[psf_pkg::SAMPLE_W-1:0];
  assign saturated_o = fifo_data[psf_pkg::SAMPLE_W];

  // A shown result is always one the credit count still owes
  a_out_credited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_q != '0))
    else $error("result shown with no sample outstanding");

  // Ready drops only when every slot is promised
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (pending_q == PW'(CAP)))
    else $error("input stalled with free buffer slots");

  // A delivered result with no new sample releases exactly one credit
  a_credit_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_accept && !proc_accept) |=> (pending_q == $past(pending_q) - PW'(1)))
    else $error("credit count out of step with delivered results");

  // Clipped results sit at a range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      ((shaped_o == psf_pkg::SAMPLE_W'(psf_pkg::SHAPED_MAX)) ||
       (shaped_o == psf_pkg::SAMPLE_W'(psf_pkg::SHAPED_MIN))))
    else $error("saturated result not at a range limit");

endmodule

// ===== test/psf_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psf_checker - result checker of the pulse shaping FIR
// Watches the configuration, input and result channels of the block, keeps
// its own copy of kernel, history and tap count, predicts one shaped sample
// per accepted sample beat and compares every result beat against it.
// ----------------------------------------------------------------------------
module psf_checker #(
  parameter int unsigned MAX_TAPS = psf_pkg::MAX_TAPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [psf_pkg::TAP_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                action_i,
  input  logic signed [psf_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                first_of_signal_i,
  input  logic [psf_pkg::IDX_W-1:0]           coef_index_i,
  input  logic signed [psf_pkg::COEF_W-1:0]   coef_value_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [psf_pkg::SAMPLE_W-1:0] shaped_i,
  input  logic                                saturated_i,
  output int unsigned                         pending_o,
  output int unsigned                         fail_count_o
);

  typedef struct packed {
    logic signed [psf_pkg::SAMPLE_W-1:0] shaped;
    logic                                saturated;
  } shaped_beat_t;

  logic signed [psf_pkg::COEF_W-1:0] kernel_m  [MAX_TAPS];
  logic [psf_pkg::HIST_W-1:0]        history_m [MAX_TAPS];
  logic [psf_pkg::TAP_W-1:0]         tap_count_m;
  shaped_beat_t                      shaped_q [$];
  shaped_beat_t                      oldest;
  int unsigned                       fail_count;

  assign fail_count_o = fail_count;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Advance the history by one sample and work out the shaped value.
  function automatic shaped_beat_t shape_sample(
    input logic signed [psf_pkg::SAMPLE_W-1:0] smp,
    input logic first
  );
    longint       acc;
    int unsigned  taps;
    int           n;
    shaped_beat_t res;
    if (first) begin
      foreach (history_m[i]) history_m[i] = '0;
    end
    for (n = MAX_TAPS - 1; n > 0; n--) history_m[n] = history_m[n-1];
    history_m[0] = (smp > 0) ? smp[psf_pkg::HIST_W-1:0] : '0;
    taps = (tap_count_m > MAX_TAPS) ? MAX_TAPS : tap_count_m;
    acc  = 0;
    for (n = 0; n < taps; n++) begin
      acc += longint'(kernel_m[n]) * longint'(history_m[n]);
    end
    acc = (acc + longint'(2 ** (psf_pkg::COEF_FRAC_BITS - 1))) >>> psf_pkg::COEF_FRAC_BITS;
    res.saturated = 1'b1;
    if (acc > psf_pkg::SHAPED_MAX) begin
      acc = psf_pkg::SHAPED_MAX;
    end else if (acc < psf_pkg::SHAPED_MIN) begin
      acc = psf_pkg::SHAPED_MIN;
    end else begin
      res.saturated = 1'b0;
    end
    res.shaped = acc[psf_pkg::SAMPLE_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (kernel_m[i]) kernel_m[i] = '0;
      foreach (history_m[i]) history_m[i] = '0;
      tap_count_m = psf_pkg::TAP_COUNT_RST;
      shaped_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) tap_count_m = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (shaped_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat, shaped %0d", shaped_i));
        end else begin
          oldest = shaped_q.pop_front();
          if (shaped_i !== oldest.shaped)
            report_mismatch($sformatf("shaped %0d, want %0d", shaped_i, oldest.shaped));
          if (saturated_i !== oldest.saturated)
            report_mismatch($sformatf("saturated %b, want %b (shaped %0d)",
                                      saturated_i, oldest.saturated, oldest.shaped));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (action_i == psf_pkg::ACT_LOAD) begin
          if (coef_index_i < MAX_TAPS) kernel_m[coef_index_i] = coef_value_i;
        end else begin
          shaped_q.push_back(shape_sample(sample_i, first_of_signal_i));
        end
      end
      pending_o <= shaped_q.size();
    end
  end

endmodule

// ===== test/pulse_shaping_fir_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pulse_shaping_fir_test - testbench of the pulse shaping FIR
// Drives directed and random kernel loads and detector signals through the
// block under several tap counts, with random idling on both channels; a
// checker beside the block predicts and compares every shaped sample.
// ----------------------------------------------------------------------------
module pulse_shaping_fir_test;

  // a sample beat takes the chain plus rounding and output stages
  localparam int unsigned CHAIN_LATENCY = psf_pkg::MAX_TAPS_DEF + 3;
  localparam int unsigned SETTLE_CYCLES = CHAIN_LATENCY + 8;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned IDLE_PCT      = 17;
  localparam int unsigned PHASE_ITEMS   = 35;

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                cfg_we_i;
  logic [psf_pkg::TAP_W-1:0]           cfg_wdata_i;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic                                action_i;
  logic signed [psf_pkg::SAMPLE_W-1:0] sample_i;
  logic                                first_of_signal_i;
  logic [psf_pkg::IDX_W-1:0]           coef_index_i;
  logic signed [psf_pkg::COEF_W-1:0]   coef_value_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic signed [psf_pkg::SAMPLE_W-1:0] shaped_o;
  logic                                saturated_o;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned stall_cycles;
  bit          quiet;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pulse_shaping_fir dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .sample_i          (sample_i),
    .first_of_signal_i (first_of_signal_i),
    .coef_index_i      (coef_index_i),
    .coef_value_i      (coef_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .shaped_o          (shaped_o),
    .saturated_o       (saturated_o)
  );

  psf_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .action_i          (action_i),
    .sample_i          (sample_i),
    .first_of_signal_i (first_of_signal_i),
    .coef_index_i      (coef_index_i),
    .coef_value_i      (coef_value_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .shaped_i          (shaped_o),
    .saturated_i       (saturated_o),
    .pending_o         (pending),
    .fail_count_o      (fail_count)
  );

  // Stall the result side at random, except through the quiet stretch.
  always @(posedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: end the run when no beat moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("[pulse_shaping_fir] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one input beat, idling at random first, and hold it until taken.
  // Returns at the edge that accepts it, leaving valid high for the next one.
  task automatic send_beat(input psf_pkg::psf_action_e act,
                           input logic signed [psf_pkg::SAMPLE_W-1:0] smp,
                           input logic first, input logic [psf_pkg::IDX_W-1:0] idx,
                           input logic signed [psf_pkg::COEF_W-1:0] coef);
    while (!quiet && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    action_i          <= act;
    sample_i          <= smp;
    first_of_signal_i <= first;
    coef_index_i      <= idx;
    coef_value_i      <= coef;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Unused fields carry random bits: the block has to ignore them.
  task automatic load_coef(input logic [psf_pkg::IDX_W-1:0] idx,
                           input logic signed [psf_pkg::COEF_W-1:0] coef);
    send_beat(psf_pkg::ACT_LOAD, psf_pkg::SAMPLE_W'($urandom), 1'($urandom), idx, coef);
  endtask

  task automatic shape(input logic signed [psf_pkg::SAMPLE_W-1:0] smp, input logic first);
    send_beat(psf_pkg::ACT_PROCESS, smp, first, psf_pkg::IDX_W'($urandom),
              psf_pkg::COEF_W'($urandom));
  endtask

  // Drop valid, wait for every shaped sample, then let loads clear the chain.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_taps(input logic [psf_pkg::TAP_W-1:0] taps);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= taps;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic signed [psf_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(3))
      0:       return psf_pkg::SAMPLE_W'($urandom);
      1:       return psf_pkg::SAMPLE_W'($urandom_range(2000));
      2:       return psf_pkg::SAMPLE_W'($urandom_range(32767, 20000));
      default: return psf_pkg::SAMPLE_W'(-$urandom_range(32768));
    endcase
  endfunction

  function automatic logic signed [psf_pkg::COEF_W-1:0] rand_coef();
    case ($urandom_range(3))
      0:       return psf_pkg::COEF_W'($urandom);
      3:       return '0;
      default: return psf_pkg::COEF_W'($urandom_range(6000) - 1000);
    endcase
  endfunction

  initial begin
    int unsigned               p;
    int unsigned               k;
    int unsigned               len;
    int unsigned               items;
    int unsigned               n_loads;
    int unsigned               span;
    logic [psf_pkg::TAP_W-1:0] setting;

    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    in_valid_i        <= 1'b0;
    action_i          <= psf_pkg::ACT_PROCESS;
    sample_i          <= '0;
    first_of_signal_i <= 1'b0;
    coef_index_i      <= '0;
    coef_value_i      <= '0;
    out_ready_i       <= 1'b1;
    stall_cycles      <= 0;
    quiet             = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, tap count still at its reset value.
    shape(16'sd16384, 1'b1);            // kernel all zero after reset
    load_coef(7'd0, 16'sd1);
    shape(16'sd16384, 1'b1);            // exactly half rounds up
    load_coef(7'd0, -16'sd1);
    shape(16'sd16384, 1'b1);            // negative half rounds up to zero
    shape(16'sd16385, 1'b1);
    load_coef(7'd0, 16'sh7fff);
    load_coef(7'd127, 16'sh8000);       // last tap, most negative coefficient
    shape(16'sd32767, 1'b1);
    shape(16'sh8000, 1'b0);             // negative sample counts as zero
    shape(16'sd0, 1'b0);
    load_coef(7'd1, 16'sh7fff);
    shape(16'sd32767, 1'b1);
    shape(16'sd32767, 1'b0);            // positive clip
    load_coef(7'd0, 16'sh8000);
    load_coef(7'd1, 16'sh8000);
    shape(16'sd32767, 1'b1);
    shape(16'sd32767, 1'b0);            // negative clip
    shape(16'sd1, 1'b1);

    // No taps in use: everything shapes to zero, loads still land.
    write_taps(8'd0);
    shape(16'sd32767, 1'b1);
    load_coef(7'd2, 16'sh3039);
    shape(16'sd1000, 1'b0);

    // Tap count above the chain length is taken as the full chain.
    write_taps(8'hff);
    shape(16'sd32767, 1'b1);
    shape(16'sd32767, 1'b0);

    // Random phases: reload part of the kernel, then run whole signals.
    for (p = 0; p < 6; p++) begin
      case (p)
        0:       setting = 8'd128;
        1:       setting = 8'd1;
        2:       setting = 8'd64;
        3:       setting = 8'd255;
        4:       setting = 8'd2;
        default: setting = psf_pkg::TAP_W'($urandom_range(126, 3));
      endcase
      write_taps(setting);
      quiet = (p == 3);                 // one long stretch with no idling
      span  = (setting > psf_pkg::MAX_TAPS_DEF) ? psf_pkg::MAX_TAPS_DEF : setting;
      n_loads = $urandom_range(24, 8);
      for (k = 0; k < n_loads; k++) begin
        if ($urandom_range(4) == 0) begin
          load_coef(psf_pkg::IDX_W'($urandom), rand_coef());
        end else begin
          load_coef(psf_pkg::IDX_W'($urandom_range(span - 1)), rand_coef());
        end
      end
      items = 0;
      while (items < PHASE_ITEMS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(140, 100) : $urandom_range(30, 1);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(19) == 0) begin
            load_coef(psf_pkg::IDX_W'($urandom), rand_coef());   // reload mid-signal
          end else if ($urandom_range(19) == 0) begin
            shape(rand_sample(), 1'($urandom));     // stray or missing first mark
          end else begin
            shape(rand_sample(), k == 0);
          end
          items++;
        end
      end
    end
    quiet = 1'b0;

    settle();
    if (fail_count == 0) begin
      $display("[pulse_shaping_fir] OK");
    end else begin
      $display("[pulse_shaping_fir] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/psf_pkg.sv
rtl/psf_cell.sv
rtl/psf_fifo.sv
rtl/pulse_shaping_fir.sv
test/psf_checker.sv
test/pulse_shaping_fir_test.sv
